// ===== src/trail_map_engine_unit_assert.svh =====
// Assertion macros for the trail map engine RTL.
`ifndef TRAIL_MAP_ENGINE_UNIT_ASSERT_SVH
`define TRAIL_MAP_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tme_pkg.sv =====
// Shared constants and types for the trail map engine.
package tme_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned COORD_W   = 8;
  localparam int unsigned ADDR_W    = 2 * COORD_W;
  localparam int unsigned VAL_W     = 24;
  localparam int unsigned WORD_W    = VAL_W + 1;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned SQ_W      = 2 * POS_W;
  localparam int unsigned SUM_W     = VAL_W + 4;

  localparam logic [2:0] REQ_READ    = 3'd0;
  localparam logic [2:0] REQ_ADD     = 3'd1;
  localparam logic [2:0] REQ_DECAY   = 3'd2;
  localparam logic [2:0] REQ_DIFFUSE = 3'd3;
  localparam logic [2:0] REQ_CLEAR   = 3'd4;
  localparam logic [2:0] REQ_FILL    = 3'd5;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_DECAY  = 2'd2;

  localparam logic [COORD_W-1:0] WIDTH_RST  = 8'd255;
  localparam logic [COORD_W-1:0] HEIGHT_RST = 8'd255;
  localparam logic [VAL_W-1:0]   DECAY_RST  = 24'd3;

  // Store word: fixed mark on top of the value.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } tme_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } tme_rd_t;

endpackage

// ===== src/tme_ram.sv =====
// Cell store: one write port, one registered read port.
module tme_ram (
  input  logic                            clk_i,
  input  tme_pkg::tme_wr_t                wr_i,
  input  tme_pkg::tme_rd_t                rd_i,
  output logic [tme_pkg::WORD_W-1:0]      rdata_o
);

  logic [tme_pkg::WORD_W-1:0] mem [2**tme_pkg::ADDR_W];
  logic [tme_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.re) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tme_ctrl.sv =====
// Request sequencer: walks the grid with read-modify-write on the cell store.
`include "trail_map_engine_unit_assert.svh"
module tme_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tme_pkg::COORD_W-1:0]   grid_w_i,
  input  logic [tme_pkg::COORD_W-1:0]   grid_h_i,
  input  logic [tme_pkg::VAL_W-1:0]     decay_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    req_type_i,
  input  logic [tme_pkg::POS_W-1:0]     x_pos_i,
  input  logic [tme_pkg::POS_W-1:0]     y_pos_i,
  input  logic [tme_pkg::POS_W-1:0]     radius_i,
  input  logic signed [tme_pkg::VAL_W-1:0] amount_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tme_pkg::VAL_W-1:0]     trail_value_o,
  output logic                          outside_grid_o,
  output tme_pkg::tme_wr_t              wr_o,
  output tme_pkg::tme_rd_t              rd_o,
  input  logic [tme_pkg::WORD_W-1:0]    rdata_i
);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_SRD  = 4'd2;
  localparam logic [3:0] ST_SOP  = 4'd3;
  localparam logic [3:0] ST_PRD  = 4'd4;
  localparam logic [3:0] ST_PSQ  = 4'd5;
  localparam logic [3:0] ST_PWR  = 4'd6;
  localparam logic [3:0] ST_DIF  = 4'd7;
  localparam logic [3:0] ST_DWR  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  localparam int unsigned CW = tme_pkg::COORD_W;
  localparam int unsigned VW = tme_pkg::VAL_W;
  localparam int unsigned PW = tme_pkg::POS_W;
  localparam int unsigned QW = tme_pkg::SQ_W;
  localparam int unsigned SW = tme_pkg::SUM_W;
  localparam int unsigned AW = tme_pkg::ADDR_W;

  logic [3:0]          state_q, state_d;
  logic [2:0]          req_q, req_d;
  logic [PW-1:0]       x_q, x_d, y_q, y_d;
  logic [VW-1:0]       amt_q, amt_d;
  logic [QW-1:0]       rsq_q, rsq_d;
  logic [CW-1:0]       i_q, i_d, j_q, j_d;
  logic [PW-1:0]       dx_q, dx_d, dy_q, dy_d;
  logic [QW-1:0]       sqx_q, sqx_d, sqy_q, sqy_d;
  logic [3:0]          k_q, k_d;
  logic                prev_ok_q, prev_ok_d, prev_ctr_q, prev_ctr_d;
  logic [1:0]          prev_sh_q, prev_sh_d;
  logic [SW-1:0]       sum_q, sum_d;
  logic                fix_q, fix_d;
  logic [VW-1:0]       res_val_q, res_val_d;
  logic                res_out_q, res_out_d;
  logic                out_valid_q, out_valid_d;
  logic [VW-1:0]       out_val_q, out_val_d;
  logic                out_out_q, out_out_d;
  logic [AW-1:0]       clr_q, clr_d;

  logic                in_acc;
  logic [CW-1:0]       pi, pj, ni, nj;
  logic                pt_in, nb_in, grid_empty, last_i, last_j, insd;
  logic [1:0]          nb_sh;
  logic [PW-1:0]       ci16, cj16;
  logic [VW+1:0]       add_sum;
  logic [VW-1:0]       cur_v, fill_v;
  logic [SW-1:0]       term;
  logic [3:0]          pass_st;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign pi         = x_q[PW-1 -: CW];
  assign pj         = y_q[PW-1 -: CW];
  assign pt_in      = (pi != '0) && (pi < grid_w_i) && (pj != '0) && (pj < grid_h_i);
  assign grid_empty = (grid_w_i < CW'(2)) || (grid_h_i < CW'(2));
  assign last_i     = ((CW+1)'(i_q) + (CW+1)'(1)) == (CW+1)'(grid_w_i);
  assign last_j     = ((CW+1)'(j_q) + (CW+1)'(1)) == (CW+1)'(grid_h_i);
  assign ci16       = PW'(i_q) << tme_pkg::FRAC_BITS;
  assign cj16       = PW'(j_q) << tme_pkg::FRAC_BITS;
  assign insd       = ((QW+1)'(sqx_q) + (QW+1)'(sqy_q)) < (QW+1)'(rsq_q);
  assign cur_v      = rdata_i[VW-1:0];
  assign fill_v     = amt_q[VW-1] ? '0 : amt_q;
  assign add_sum    = {2'b00, cur_v} + {{2{amt_q[VW-1]}}, amt_q};
  assign term       = prev_ok_q ? (SW'(cur_v) << prev_sh_q) : '0;
  assign pass_st    = (req_q == tme_pkg::REQ_DIFFUSE) ? ST_DIF : ST_PRD;

  // 3x3 neighbour k: row offset from k/3, column offset from k%3
  always_comb begin
    ni    = i_q;
    nj    = j_q;
    nb_sh = 2'd0;
    unique case (k_q)
      4'd0: begin ni = i_q - 1'b1; nj = j_q - 1'b1; nb_sh = 2'd0; end
      4'd1: begin ni = i_q - 1'b1;                  nb_sh = 2'd1; end
      4'd2: begin ni = i_q - 1'b1; nj = j_q + 1'b1; nb_sh = 2'd0; end
      4'd3: begin                  nj = j_q - 1'b1; nb_sh = 2'd1; end
      4'd4: begin                                   nb_sh = 2'd2; end
      4'd5: begin                  nj = j_q + 1'b1; nb_sh = 2'd1; end
      4'd6: begin ni = i_q + 1'b1; nj = j_q - 1'b1; nb_sh = 2'd0; end
      4'd7: begin ni = i_q + 1'b1;                  nb_sh = 2'd1; end
      4'd8: begin ni = i_q + 1'b1; nj = j_q + 1'b1; nb_sh = 2'd0; end
      default: begin ni = i_q; nj = j_q; nb_sh = 2'd0; end
    endcase
  end
  assign nb_in = (ni != '0) && (ni < grid_w_i) && (nj != '0) && (nj < grid_h_i);

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    x_d        = x_q;
    y_d        = y_q;
    amt_d      = amt_q;
    rsq_d      = rsq_q;
    i_d        = i_q;
    j_d        = j_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    sqx_d      = sqx_q;
    sqy_d      = sqy_q;
    k_d        = k_q;
    prev_ok_d  = prev_ok_q;
    prev_ctr_d = prev_ctr_q;
    prev_sh_d  = prev_sh_q;
    sum_d      = sum_q;
    fix_d      = fix_q;
    res_val_d  = res_val_q;
    res_out_d  = res_out_q;
    out_val_d  = out_val_q;
    out_out_d  = out_out_q;
    clr_d      = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_o       = '0;
    rd_o       = '0;

    unique case (state_q)
      ST_CLR: begin
        wr_o.we   = 1'b1;
        wr_o.addr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          req_d     = req_type_i;
          x_d       = x_pos_i;
          y_d       = y_pos_i;
          amt_d     = amount_i;
          rsq_d     = radius_i * radius_i;
          res_val_d = '0;
          res_out_d = 1'b0;
          i_d       = CW'(1);
          j_d       = CW'(1);
          k_d       = '0;
          priority if (req_type_i == tme_pkg::REQ_READ ||
                       req_type_i == tme_pkg::REQ_ADD) begin
            state_d = ST_SRD;
          end else if (req_type_i == tme_pkg::REQ_DIFFUSE) begin
            state_d = grid_empty ? ST_DONE : ST_DIF;
          end else if (req_type_i == tme_pkg::REQ_DECAY ||
                       req_type_i == tme_pkg::REQ_CLEAR ||
                       req_type_i == tme_pkg::REQ_FILL) begin
            state_d = grid_empty ? ST_DONE : ST_PRD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SRD: begin
        if (pt_in) begin
          rd_o.re   = 1'b1;
          rd_o.addr = {pi, pj};
          state_d   = ST_SOP;
        end else begin
          res_out_d = (req_q == tme_pkg::REQ_READ);
          state_d   = ST_DONE;
        end
      end
      ST_SOP: begin
        if (req_q == tme_pkg::REQ_READ) begin
          res_val_d = cur_v;
        end else if (!rdata_i[VW]) begin
          wr_o.we   = 1'b1;
          wr_o.addr = {pi, pj};
          priority if (add_sum[VW+1]) begin
            wr_o.data = '0;
          end else if (add_sum[VW]) begin
            wr_o.data = {1'b0, {VW{1'b1}}};
          end else begin
            wr_o.data = {1'b0, add_sum[VW-1:0]};
          end
        end
        state_d = ST_DONE;
      end
      ST_PRD: begin
        rd_o.re   = 1'b1;
        rd_o.addr = {i_q, j_q};
        dx_d      = (x_q >= ci16) ? (x_q - ci16) : (ci16 - x_q);
        dy_d      = (y_q >= cj16) ? (y_q - cj16) : (cj16 - y_q);
        state_d   = ST_PSQ;
      end
      ST_PSQ: begin
        sqx_d   = dx_q * dx_q;
        sqy_d   = dy_q * dy_q;
        state_d = ST_PWR;
      end
      ST_PWR: begin
        wr_o.addr = {i_q, j_q};
        unique case (req_q)
          tme_pkg::REQ_DECAY: begin
            wr_o.we   = !rdata_i[VW];
            wr_o.data = {1'b0, (cur_v > decay_i) ? (cur_v - decay_i) : '0};
          end
          tme_pkg::REQ_CLEAR: begin
            wr_o.we   = !rdata_i[VW] && insd;
            wr_o.data = '0;
          end
          tme_pkg::REQ_FILL: begin
            wr_o.we   = insd;
            wr_o.data = {1'b1, fill_v};
          end
          default: begin
            wr_o.we   = 1'b0;
          end
        endcase
      end
      ST_DIF: begin
        // read neighbour k while the data of neighbour k-1 comes back
        if (k_q != 4'd9) begin
          rd_o.re    = 1'b1;
          rd_o.addr  = {ni, nj};
          prev_ok_d  = nb_in;
          prev_sh_d  = nb_sh;
          prev_ctr_d = (k_q == 4'd4);
        end
        if (k_q == '0) begin
          sum_d = '0;
        end else begin
          sum_d = sum_q + term;
          if (prev_ctr_q) begin
            fix_d = rdata_i[VW];
          end
        end
        k_d = k_q + 1'b1;
        if (k_q == 4'd9) begin
          state_d = ST_DWR;
        end
      end
      ST_DWR: begin
        wr_o.we   = !fix_q;
        wr_o.addr = {i_q, j_q};
        wr_o.data = {1'b0, sum_q[SW-1 -: VW]};
        k_d       = '0;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_out_d   = res_out_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // raster step in each cell's write-back state, whether or not the cell is written
    if (state_q == ST_PWR || state_q == ST_DWR) begin
      if (last_j) begin
        j_d = CW'(1);
        i_d = i_q + 1'b1;
      end else begin
        j_d = j_q + 1'b1;
      end
      state_d = (last_j && last_i) ? ST_DONE : pass_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    x_q        <= x_d;
    y_q        <= y_d;
    amt_q      <= amt_d;
    rsq_q      <= rsq_d;
    i_q        <= i_d;
    j_q        <= j_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    sqx_q      <= sqx_d;
    sqy_q      <= sqy_d;
    prev_ok_q  <= prev_ok_d;
    prev_ctr_q <= prev_ctr_d;
    prev_sh_q  <= prev_sh_d;
    sum_q      <= sum_d;
    fix_q      <= fix_d;
    res_val_q  <= res_val_d;
    res_out_q  <= res_out_d;
    out_val_q  <= out_val_d;
    out_out_q  <= out_out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign trail_value_o  = out_val_q;
  assign outside_grid_o = out_out_q;

  `TME_ASSERT_IMP(a_idle_no_write, state_q == ST_IDLE, !wr_o.we, "store written while idle")
  `TME_ASSERT_IMP(a_write_interior, wr_o.we && state_q != ST_CLR,
    wr_o.addr[AW-1 -: CW] != '0 && wr_o.addr[CW-1:0] != '0, "write to border cell")
  `TME_ASSERT_NXT(a_accept_busy, in_acc, state_q != ST_IDLE, "request accepted but not started")
  `TME_ASSERT_IMP(a_no_rw_clash, rd_o.re, !wr_o.we, "read and write in one cycle")

endmodule

// ===== src/trail_map_engine_unit.sv =====
// Top level of the trail map engine: configuration registers and cell store.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+----------------------------------------
//  request  | in        | in_valid_i / in_stall_o  | req_type_i x_pos_i y_pos_i radius_i
//           |           |                          | amount_i
//  result   | out       | out_valid_o / out_stall_i| trail_value_o outside_grid_o
//  config   | in        | cfg_we_i                 | cfg_index_i cfg_data_i
//
// After reset all 65536 cells of the store are swept to zero, one cell a cycle,
// with in_stall_o high. After a request is taken, read and add read the cell and
// then use or write it (the cell is not read when it lies outside the interior);
// decay, clear disc and fill disc read each interior cell, square its distances
// and write it back; diffuse reads the nine neighbours of each interior cell in
// turn through the single read port, adds in the last, then writes back. The
// result register is then loaded, and the block goes idle before the next request.
// One request is in work at a time; the result register lets the next request
// be taken while a result is still held by out_stall_i.
module trail_map_engine_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       req_type_i,
  input  logic [tme_pkg::POS_W-1:0]        x_pos_i,
  input  logic [tme_pkg::POS_W-1:0]        y_pos_i,
  input  logic [tme_pkg::POS_W-1:0]        radius_i,
  input  logic signed [tme_pkg::VAL_W-1:0] amount_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [tme_pkg::VAL_W-1:0]        trail_value_o,
  output logic                             outside_grid_o,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_index_i,
  input  logic [tme_pkg::VAL_W-1:0]        cfg_data_i
);

  logic [tme_pkg::COORD_W-1:0] grid_w_q, grid_h_q;
  logic [tme_pkg::VAL_W-1:0]   decay_q;
  tme_pkg::tme_wr_t            wr;
  tme_pkg::tme_rd_t            rd;
  logic [tme_pkg::WORD_W-1:0]  rdata;

  // config writes; an unused index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= tme_pkg::WIDTH_RST;
      grid_h_q <= tme_pkg::HEIGHT_RST;
      decay_q  <= tme_pkg::DECAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tme_pkg::CFG_WIDTH:  grid_w_q <= cfg_data_i[tme_pkg::COORD_W-1:0];
        tme_pkg::CFG_HEIGHT: grid_h_q <= cfg_data_i[tme_pkg::COORD_W-1:0];
        tme_pkg::CFG_DECAY:  decay_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tme_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .grid_w_i       (grid_w_q),
    .grid_h_i       (grid_h_q),
    .decay_i        (decay_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .x_pos_i        (x_pos_i),
    .y_pos_i        (y_pos_i),
    .radius_i       (radius_i),
    .amount_i       (amount_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .trail_value_o  (trail_value_o),
    .outside_grid_o (outside_grid_o),
    .wr_o           (wr),
    .rd_o           (rd),
    .rdata_i        (rdata)
  );

  tme_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

endmodule

// ===== verif/tb_trail_map_engine_unit.sv =====
// Self-checking testbench for the trail map engine: directed and random requests.
`timescale 1ns / 1ps

module tb_trail_map_engine_unit;

  // Spare request codes have no function in the block.
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT = 1500000;
  localparam int unsigned LONG_HOLD      = 300;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic [2:0]                       req_type_i = tme_pkg::REQ_READ;
  logic [tme_pkg::POS_W-1:0]        x_pos_i = '0;
  logic [tme_pkg::POS_W-1:0]        y_pos_i = '0;
  logic [tme_pkg::POS_W-1:0]        radius_i = '0;
  logic signed [tme_pkg::VAL_W-1:0] amount_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [tme_pkg::VAL_W-1:0]        trail_value_o;
  logic                             outside_grid_o;
  logic                             cfg_we_i = 1'b0;
  logic [1:0]                       cfg_index_i = tme_pkg::CFG_WIDTH;
  logic [tme_pkg::VAL_W-1:0]        cfg_data_i = '0;

  trail_map_engine_unit u_top (.*);

  always #1 clk_i = ~clk_i;

  // Shadow copy of the grid and its registers.
  logic [tme_pkg::VAL_W-1:0] shadow_value [0:65535];
  bit                        shadow_fixed [0:65535];
  logic [7:0]                grid_w;
  logic [7:0]                grid_h;
  logic [tme_pkg::VAL_W-1:0] decay_step;

  typedef struct {
    logic [tme_pkg::VAL_W-1:0] value;
    logic                      outside;
  } trail_result_t;

  trail_result_t pending_results[$];
  int unsigned   fail_count;
  int unsigned   requests_sent;
  int unsigned   results_seen;
  int unsigned   passes_run;
  int unsigned   idle_cycles;
  bit            hold_off_req;
  int unsigned   stall_waits;

  function automatic bit is_interior(int unsigned i, int unsigned j);
    return i >= 1 && i < grid_w && j >= 1 && j < grid_h;
  endfunction

  function automatic longint unsigned cell_of(int unsigned i, int unsigned j);
    if (!is_interior(i, j)) return 0;
    return shadow_value[i * 256 + j];
  endfunction

  function automatic bit within_disc(longint unsigned x, longint unsigned y,
                                     longint unsigned r, int unsigned i, int unsigned j);
    longint unsigned ci, cj, dx, dy;
    ci = longint'(i) << tme_pkg::FRAC_BITS;
    cj = longint'(j) << tme_pkg::FRAC_BITS;
    dx = x > ci ? x - ci : ci - x;
    dy = y > cj ? y - cj : cj - y;
    return dx * dx + dy * dy < r * r;
  endfunction

  // Applies one request to the shadow grid and returns what the block should answer.
  function automatic trail_result_t apply_request(logic [2:0] req, logic [15:0] x,
      logic [15:0] y, logic [15:0] r, logic signed [tme_pkg::VAL_W-1:0] amt);
    trail_result_t   res;
    int unsigned     ci, cj, k;
    longint          sum;
    longint unsigned acc;
    res.value   = '0;
    res.outside = 1'b0;
    ci = x >> tme_pkg::FRAC_BITS;
    cj = y >> tme_pkg::FRAC_BITS;
    case (req)
      tme_pkg::REQ_READ: begin
        if (is_interior(ci, cj)) res.value = shadow_value[ci * 256 + cj];
        else res.outside = 1'b1;
      end
      tme_pkg::REQ_ADD: begin
        k = ci * 256 + cj;
        if (is_interior(ci, cj) && !shadow_fixed[k]) begin
          sum = longint'(shadow_value[k]) + longint'(amt);
          if (sum < 0) sum = 0;
          if (sum > 64'hFFFFFF) sum = 64'hFFFFFF;
          shadow_value[k] = sum[tme_pkg::VAL_W-1:0];
        end
      end
      tme_pkg::REQ_DECAY: begin
        for (int unsigned i = 1; i < grid_w; i++)
          for (int unsigned j = 1; j < grid_h; j++) begin
            k = i * 256 + j;
            if (!shadow_fixed[k])
              shadow_value[k] = shadow_value[k] > decay_step ?
                                shadow_value[k] - decay_step : '0;
          end
      end
      tme_pkg::REQ_DIFFUSE: begin
        // In place: earlier cells of this pass already hold their new values.
        for (int unsigned i = 1; i < grid_w; i++)
          for (int unsigned j = 1; j < grid_h; j++) begin
            if (shadow_fixed[i * 256 + j]) continue;
            acc = cell_of(i - 1, j - 1) + 2 * cell_of(i, j - 1) + cell_of(i + 1, j - 1)
                + 2 * cell_of(i - 1, j) + 4 * cell_of(i, j) + 2 * cell_of(i + 1, j)
                + cell_of(i - 1, j + 1) + 2 * cell_of(i, j + 1) + cell_of(i + 1, j + 1);
            shadow_value[i * 256 + j] = acc[tme_pkg::VAL_W+3:4];
          end
      end
      tme_pkg::REQ_CLEAR: begin
        for (int unsigned i = 1; i < grid_w; i++)
          for (int unsigned j = 1; j < grid_h; j++)
            if (!shadow_fixed[i * 256 + j] && within_disc(x, y, r, i, j))
              shadow_value[i * 256 + j] = '0;
      end
      tme_pkg::REQ_FILL: begin
        for (int unsigned i = 1; i < grid_w; i++)
          for (int unsigned j = 1; j < grid_h; j++)
            if (within_disc(x, y, r, i, j)) begin
              shadow_value[i * 256 + j] = amt < 0 ? '0 : amt;
              shadow_fixed[i * 256 + j] = 1'b1;
            end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Valid stays high between back-to-back requests; it drops across a random gap (and in drop_valid).
  task automatic send_request(logic [2:0] req, logic [15:0] x, logic [15:0] y,
                              logic [15:0] r, logic signed [tme_pkg::VAL_W-1:0] amt);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= req;
    x_pos_i    <= x;
    y_pos_i    <= y;
    radius_i   <= r;
    amount_i   <= amt;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
      stall_waits++;
    end
    pending_results.push_back(apply_request(req, x, y, r, amt));
    requests_sent++;
    if (req inside {tme_pkg::REQ_DECAY, tme_pkg::REQ_DIFFUSE, tme_pkg::REQ_CLEAR,
                    tme_pkg::REQ_FILL}) passes_run++;
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Waits for the block to drain, then writes one register.
  task automatic write_reg(logic [1:0] idx, logic [tme_pkg::VAL_W-1:0] data);
    drop_valid();
    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tme_pkg::CFG_WIDTH:  grid_w = data[7:0];
      tme_pkg::CFG_HEIGHT: grid_h = data[7:0];
      tme_pkg::CFG_DECAY:  decay_step = data;
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [7:0] w, logic [7:0] h, logic [tme_pkg::VAL_W-1:0] d);
    write_reg(tme_pkg::CFG_WIDTH, w);
    write_reg(tme_pkg::CFG_HEIGHT, h);
    write_reg(tme_pkg::CFG_DECAY, d);
  endtask

  function automatic logic [15:0] cell_pos(int unsigned i, int unsigned j_frac);
    return 16'((i << tme_pkg::FRAC_BITS) | j_frac);
  endfunction

  function automatic logic [15:0] rand_coord(int unsigned lim);
    int unsigned top;
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    top = (lim + 1) * 256 + 255;
    if (top > 65535) top = 65535;
    return 16'($urandom_range(0, top));
  endfunction

  function automatic logic [15:0] rand_radius();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) return '0;
    if (p < 15) return 16'hFFFF;
    if (p < 20) return 16'($urandom);
    return 16'($urandom_range(1, 1024));
  endfunction

  function automatic logic signed [tme_pkg::VAL_W-1:0] rand_amount();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 30) return tme_pkg::VAL_W'($urandom_range(0, 4096));
    if (p < 50) return -tme_pkg::VAL_W'($urandom_range(1, 4096));
    if (p < 80) return tme_pkg::VAL_W'($urandom);
    if (p < 90) return 24'h7FFFFF;
    return 24'h800000;
  endfunction

  // Reads and adds on the reset-size grid, border and saturation included, plus a spare code.
  task automatic test_reset_grid();
    send_request(tme_pkg::REQ_READ, 16'h0000, 16'h0000, '0, '0);
    send_request(tme_pkg::REQ_READ, cell_pos(1, 8'h80), cell_pos(1, 8'hFF), '0, '0);
    send_request(tme_pkg::REQ_READ, cell_pos(254, 0), cell_pos(254, 0), '0, '0);
    send_request(tme_pkg::REQ_READ, 16'hFFFF, cell_pos(3, 0), '0, '0);
    send_request(tme_pkg::REQ_ADD, cell_pos(254, 0), cell_pos(254, 0), '0, 24'h7FFFFF);
    send_request(tme_pkg::REQ_ADD, cell_pos(254, 0), cell_pos(254, 0), '0, 24'h7FFFFF);
    send_request(tme_pkg::REQ_ADD, cell_pos(254, 0), cell_pos(254, 0), '0, 24'h7FFFFF);
    send_request(tme_pkg::REQ_READ, cell_pos(254, 0), cell_pos(254, 0), '0, '0);
    send_request(tme_pkg::REQ_ADD, cell_pos(1, 0), cell_pos(1, 0), '0, 24'd100);
    send_request(tme_pkg::REQ_ADD, cell_pos(1, 0), cell_pos(1, 0), '0, 24'h800000);
    send_request(tme_pkg::REQ_READ, cell_pos(1, 0), cell_pos(1, 0), '0, '0);
    // Border cell must ignore an add.
    send_request(tme_pkg::REQ_ADD, cell_pos(255, 0), cell_pos(7, 0), '0, 24'd500);
    send_request(tme_pkg::REQ_READ, cell_pos(255, 0), cell_pos(7, 0), '0, '0);
    send_request(REQ_SPARE_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
  endtask

  // One decay pass over the full-size grid; slow, so run once.
  task automatic test_full_decay();
    send_request(tme_pkg::REQ_ADD, cell_pos(100, 0), cell_pos(200, 0), '0, 24'd2);
    send_request(tme_pkg::REQ_DECAY, '0, '0, '0, '0);
    send_request(tme_pkg::REQ_READ, cell_pos(254, 0), cell_pos(254, 0), '0, '0);
    send_request(tme_pkg::REQ_READ, cell_pos(100, 0), cell_pos(200, 0), '0, '0);
  endtask

  // Smallest grid: one interior cell; also an empty disc and a spare code.
  task automatic test_tiny_grid();
    set_grid(8'd2, 8'd2, 24'hFFFFFF);
    send_request(tme_pkg::REQ_ADD, cell_pos(1, 0), cell_pos(1, 0), '0, 24'd4000);
    send_request(tme_pkg::REQ_DIFFUSE, '0, '0, '0, '0);
    send_request(tme_pkg::REQ_READ, cell_pos(1, 0), cell_pos(1, 0), '0, '0);
    send_request(tme_pkg::REQ_READ, cell_pos(2, 0), cell_pos(1, 0), '0, '0);
    send_request(tme_pkg::REQ_FILL, cell_pos(1, 0), cell_pos(1, 0), '0, 24'd77);
    send_request(tme_pkg::REQ_READ, cell_pos(1, 0), cell_pos(1, 0), '0, '0);
    send_request(tme_pkg::REQ_DECAY, '0, '0, '0, '0);
    send_request(tme_pkg::REQ_READ, cell_pos(1, 0), cell_pos(1, 0), '0, '0);
    send_request(REQ_SPARE_LO, '0, '0, '0, '0);
  endtask

  // Mid-size grid: fixed cells survive clear, decay and diffuse; negative fill clamps.
  task automatic test_disc_ops();
    set_grid(8'd9, 8'd6, '0);
    for (int unsigned i = 2; i < 6; i++)
      send_request(tme_pkg::REQ_ADD, cell_pos(i, 0), cell_pos(3, 0), '0,
                   tme_pkg::VAL_W'(i * 1000));
    send_request(tme_pkg::REQ_FILL, cell_pos(4, 0), cell_pos(2, 0), 16'h0180, 24'hFFFF00);
    send_request(tme_pkg::REQ_FILL, cell_pos(7, 8'h80), cell_pos(4, 8'h80), 16'h0100,
                 24'h00ABCD);
    send_request(tme_pkg::REQ_DIFFUSE, '0, '0, '0, '0);
    send_request(tme_pkg::REQ_CLEAR, cell_pos(3, 0), cell_pos(3, 0), 16'h0200, '0);
    send_request(tme_pkg::REQ_DECAY, '0, '0, '0, '0);
    send_request(tme_pkg::REQ_READ, cell_pos(7, 0), cell_pos(4, 0), '0, '0);
    send_request(tme_pkg::REQ_READ, cell_pos(5, 0), cell_pos(3, 0), '0, '0);
    send_request(tme_pkg::REQ_READ, cell_pos(8, 0), cell_pos(5, 0), '0, '0);
  endtask

  // Random traffic over several grid shapes, including the long receiver hold.
  task automatic test_random_traffic();
    logic [2:0]  req;
    int unsigned p;
    for (int unsigned phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_grid(8'd255, 8'd2, 24'd0);
        1: set_grid(8'd2, 8'd255, 24'd1);
        default: set_grid(8'($urandom_range(2, 12)), 8'($urandom_range(2, 12)),
                          tme_pkg::VAL_W'($urandom_range(0, 3) == 0 ? $urandom :
                                                                $urandom_range(0, 600)));
      endcase
      if (phase == 3) hold_off_req = 1'b1;
      for (int unsigned n = 0; n < 13; n++) begin
        p = $urandom_range(0, 99);
        if (p < 35) req = tme_pkg::REQ_READ;
        else if (p < 65) req = tme_pkg::REQ_ADD;
        else if (p < 73) req = tme_pkg::REQ_DECAY;
        else if (p < 81) req = tme_pkg::REQ_DIFFUSE;
        else if (p < 88) req = tme_pkg::REQ_CLEAR;
        else if (p < 96) req = tme_pkg::REQ_FILL;
        else req = p[0] ? REQ_SPARE_LO : REQ_SPARE_HI;
        send_request(req, rand_coord(grid_w), rand_coord(grid_h), rand_radius(),
                     rand_amount());
      end
    end
  endtask

  // Result side: random stall, plus one long hold that backs the block up.
  initial begin
    int unsigned hold;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        hold = 0;
        while (hold < LONG_HOLD) begin
          @(negedge clk_i);
          hold++;
        end
        hold_off_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= pick_gap() > 0;
      end
    end
  end

  always @(posedge clk_i) begin
    trail_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h outside=%b", $time,
                 trail_value_o, outside_grid_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (trail_value_o !== want.value) begin
          $display("%0t: trail_value expected %h actual %h", $time, want.value,
                   trail_value_o);
          fail_count++;
        end
        if (outside_grid_o !== want.outside) begin
          $display("%0t: outside_grid expected %b actual %b", $time, want.outside,
                   outside_grid_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles in which neither channel moves a request or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned settle;
    for (int k = 0; k < 65536; k++) begin
      shadow_value[k] = '0;
      shadow_fixed[k] = 1'b0;
    end
    grid_w = tme_pkg::WIDTH_RST;
    grid_h = tme_pkg::HEIGHT_RST;
    decay_step = tme_pkg::DECAY_RST;
    fail_count = 0;
    requests_sent = 0;
    results_seen = 0;
    passes_run = 0;
    idle_cycles = 0;
    stall_waits = 0;
    hold_off_req = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_grid();
    test_full_decay();
    test_tiny_grid();
    test_disc_ops();
    test_random_traffic();
    drop_valid();

    wait (pending_results.size() == 0);
    settle = 0;
    while (settle < 20) begin
      @(posedge clk_i);
      settle++;
    end
    $display("Covered %0d requests (%0d grid passes), %0d results checked,",
             requests_sent, passes_run, results_seen);
    $display("grid shapes from 1x1 to 254x254, input back-pressure on %0d cycles.",
             stall_waits);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
